/* rtl/core/assert_macros.svh */
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication, disabled during reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked implication checked during reset as well
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/core/glzw_pkg.sv */
// ----------------------------------------------------------------------------
// glzw_pkg
// Types, codes and constants for the GIF LZW decoder.
// ----------------------------------------------------------------------------
package glzw_pkg;

  localparam int MAX_CODE_BITS_DEF = 12;

  typedef enum logic [1:0] {
    OP_PUSH    = 2'd0,
    OP_PULL    = 2'd1,
    OP_RESTART = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NEED     = 3'd1,
    ST_REJECT   = 3'd2,
    ST_END      = 3'd3,
    ST_OVERFLOW = 3'd4,
    ST_INVALID  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    FIN_RUN      = 2'd0,
    FIN_END      = 2'd1,
    FIN_OVERFLOW = 2'd2,
    FIN_INVALID  = 2'd3
  } fin_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_WALK,
    S_WAIT,
    S_FIX,
    S_POP,
    S_PIX,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] pixel_index;
    logic       pixel_valid;
    logic [2:0] status;
  } out_item_t;

endpackage

/* rtl/core/gif_lzw_decoder.sv */
// ----------------------------------------------------------------------------
// gif_lzw_decoder
// Variable-width GIF LZW decoder with dictionary and pixel stack in RAM.
// ----------------------------------------------------------------------------
// One beat in gives one beat out; the next beat is taken only after the result
// has left. A push, restart, idle op or a pull that only reports a status goes
// from decode to out; a pull that pops the stack goes through decode, stack
// read (pop), pixel and out. A pull on an empty stack decodes first: a decode
// step per code consumed (clear codes included), a walk and a wait step per
// dictionary chain entry read through the synchronous prefix/suffix RAM, a
// closing walk step that adds the table entry, a fix step when the code equals
// the next free entry, then the pop. The tables are not cleared after reset.
module gif_lzw_decoder
  import glzw_pkg::*;
#(
  parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [3:0] cfg_data
);

  `include "assert_macros.svh"

  localparam int DEPTH = 1 << MAX_CODE_BITS;
  localparam int AW    = MAX_CODE_BITS;
  localparam int CW    = MAX_CODE_BITS + 1;   // code with none marker room
  localparam logic [CW-1:0] CODE_NONE = {CW{1'b1}};

  // memories
  logic [AW-1:0] prefix_mem [DEPTH];
  logic [7:0]    suffix_mem [DEPTH];
  logic [7:0]    stack_mem  [DEPTH];

  logic [3:0]    min_code_size;
  logic [CW:0]   stack_count, stack_count_next;
  logic [23:0]   bit_buffer, bit_buffer_next;
  logic [4:0]    bit_count, bit_count_next;
  logic [3:0]    code_width, code_width_next;
  logic [CW:0]   next_free, next_free_next;
  logic [CW-1:0] prev_code, prev_code_next;
  fin_t          fin, fin_next;
  state_t        state, state_next;

  logic [1:0]    op_reg;
  logic [7:0]    in_q_byte;
  logic [CW-1:0] cur_code, cur_code_next;    // code being decoded
  logic [AW-1:0] walk, walk_next;            // chain pointer
  logic          kwk, kwk_next;
  logic [CW:0]   wn, wn_next;                // stack write position
  out_item_t     res, res_next;
  logic          out_full;

  // memory ports
  logic          tab_we, stk_we;
  logic [AW-1:0] tab_waddr, stk_waddr, tab_raddr, stk_raddr;
  logic [AW-1:0] tab_wpre;
  logic [7:0]    tab_wsuf, stk_wdata;
  logic [AW-1:0] pre_q;
  logic [7:0]    suf_q, stk_q;
  logic [7:0]    first_reg, first_next;

  always_ff @(posedge clk) begin
    if (tab_we) begin
      prefix_mem[tab_waddr] <= tab_wpre;
      suffix_mem[tab_waddr] <= tab_wsuf;
    end
    pre_q <= prefix_mem[tab_raddr];
    suf_q <= suffix_mem[tab_raddr];
    if (stk_we) stack_mem[stk_waddr] <= stk_wdata;
    stk_q <= stack_mem[stk_raddr];
  end

  // clamped minimum code size
  logic [3:0] m_eff;
  always_comb begin
    m_eff = min_code_size;
    if (m_eff < 4'd2) m_eff = 4'd2;
    if (m_eff > 4'd8) m_eff = 4'd8;
  end
  logic [CW-1:0] clr_code;
  assign clr_code = CW'(1) << m_eff;

  logic [3:0]    w_use;
  logic [CW-1:0] code_x;
  always_comb begin
    w_use = code_width;
    if (w_use < 4'd1 || 32'(w_use) > MAX_CODE_BITS) w_use = m_eff + 4'd1;
    code_x = CW'(bit_buffer & ((24'd1 << w_use) - 24'd1));
  end

  assign in_stall  = (state != S_IDLE) || out_full;
  assign cfg_ready = (state == S_IDLE);
  assign out_valid = out_full;
  assign out_data  = res;

  logic in_acc;
  assign in_acc = in_valid && !in_stall;

  always_comb begin
    state_next       = state;
    stack_count_next = stack_count;
    bit_buffer_next  = bit_buffer;
    bit_count_next   = bit_count;
    code_width_next  = code_width;
    next_free_next   = next_free;
    prev_code_next   = prev_code;
    fin_next         = fin;
    cur_code_next    = cur_code;
    walk_next        = walk;
    kwk_next         = kwk;
    wn_next          = wn;
    res_next         = res;
    first_next       = first_reg;
    tab_we    = 1'b0;
    tab_waddr = next_free[AW-1:0];
    tab_wpre  = prev_code[AW-1:0];
    tab_wsuf  = first_reg;
    tab_raddr = walk;
    stk_we    = 1'b0;
    stk_waddr = wn[AW-1:0];
    stk_wdata = suf_q;
    stk_raddr = AW'(stack_count - 1'b1);
    unique case (state)
      S_IDLE: begin
        if (in_acc) state_next = S_DECODE;
      end
      S_DECODE: begin
        res_next = '{pixel_index: 8'd0, pixel_valid: 1'b0, status: ST_OK};
        state_next = S_OUT;
        unique case (op_reg)
          OP_PUSH: begin
            if (fin != FIN_RUN || bit_count > 5'd16) res_next.status = ST_REJECT;
            else begin
              bit_buffer_next = bit_buffer | (24'(in_q_byte) << bit_count);
              bit_count_next  = bit_count + 5'd8;
            end
          end
          OP_PULL: begin
            if (stack_count != '0) state_next = S_POP;
            else if (fin != FIN_RUN) begin
              res_next.status = (fin == FIN_END) ? ST_END :
                                (fin == FIN_OVERFLOW) ? ST_OVERFLOW : ST_INVALID;
            end else if (5'(w_use) > bit_count) res_next.status = ST_NEED;
            else begin
              bit_buffer_next = bit_buffer >> w_use;
              bit_count_next  = bit_count - 5'(w_use);
              state_next      = S_DECODE;
              if (code_x == clr_code) begin
                code_width_next = m_eff + 4'd1;
                next_free_next  = (CW+1)'(clr_code) + 2'd2;
                prev_code_next  = CODE_NONE;
              end else if (code_x == clr_code + 1'b1) begin
                fin_next = FIN_END;
                res_next.status = ST_END;
                state_next = S_OUT;
              end else if (prev_code == CODE_NONE) begin
                if (code_x > clr_code) begin
                  fin_next = FIN_INVALID;
                  res_next.status = ST_INVALID;
                  state_next = S_OUT;
                end else begin
                  stk_we = 1'b1;
                  stk_waddr = '0;
                  stk_wdata = code_x[7:0];
                  stack_count_next = (CW+1)'(1);
                  prev_code_next = code_x;
                  state_next = S_POP;
                end
              end else if (next_free >= (CW+1)'(DEPTH)) begin
                fin_next = FIN_OVERFLOW;
                res_next.status = ST_OVERFLOW;
                state_next = S_OUT;
              end else if ((CW+1)'(code_x) > next_free) begin
                fin_next = FIN_INVALID;
                res_next.status = ST_INVALID;
                state_next = S_OUT;
              end else begin
                kwk_next = ((CW+1)'(code_x) == next_free);
                cur_code_next = code_x;
                walk_next = kwk_next ? prev_code[AW-1:0] : code_x[AW-1:0];
                wn_next = kwk_next ? (CW+1)'(1) : '0;
                state_next = S_WALK;
              end
            end
          end
          OP_RESTART: begin
            stack_count_next = '0;
            bit_buffer_next  = '0;
            bit_count_next   = '0;
            code_width_next  = m_eff + 4'd1;
            next_free_next   = (CW+1)'(clr_code) + 2'd2;
            prev_code_next   = CODE_NONE;
            fin_next         = FIN_RUN;
          end
          default: ;
        endcase
      end
      S_WALK: begin
        // issue read for walk
        if (CW'(walk) >= clr_code && wn < (CW+1)'(DEPTH - 1)) begin
          tab_raddr = walk;
          state_next = S_WAIT;
        end else begin
          // chain root: first byte of the string, then add the new entry
          first_next = walk[7:0];
          stk_we = 1'b1;
          stk_waddr = wn[AW-1:0];
          stk_wdata = walk[7:0];
          tab_we = 1'b1;
          tab_wsuf = walk[7:0];
          next_free_next = next_free + 1'b1;
          if (next_free_next == ((CW+1)'(1) << w_use) && 32'(w_use) < MAX_CODE_BITS)
            code_width_next = w_use + 4'd1;
          prev_code_next = cur_code;
          stack_count_next = wn + 1'b1;
          // KwK: slot 0 also gets the first byte, written in the fix state
          state_next = kwk ? S_FIX : S_POP;
        end
      end
      S_WAIT: begin
        stk_we = 1'b1;
        stk_waddr = wn[AW-1:0];
        stk_wdata = suf_q;
        wn_next = wn + 1'b1;
        walk_next = pre_q;
        state_next = S_WALK;
      end
      S_FIX: begin
        stk_we = 1'b1;
        stk_waddr = '0;
        stk_wdata = first_reg;
        state_next = S_POP;
      end
      S_POP: begin
        stk_raddr = AW'(stack_count - 1'b1);
        stack_count_next = stack_count - 1'b1;
        state_next = S_PIX;
      end
      S_PIX: begin
        res_next = '{pixel_index: stk_q, pixel_valid: 1'b1, status: ST_OK};
        state_next = S_OUT;
      end
      S_OUT: begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_full    <= 1'b0;
      min_code_size <= 4'd8;
      stack_count <= '0;
      bit_buffer  <= '0;
      bit_count   <= '0;
      code_width  <= 4'd9;
      next_free   <= (CW+1)'(258);
      prev_code   <= CODE_NONE;
      fin         <= FIN_RUN;
    end else begin
      state       <= state_next;
      stack_count <= stack_count_next;
      bit_buffer  <= bit_buffer_next;
      bit_count   <= bit_count_next;
      code_width  <= code_width_next;
      next_free   <= next_free_next;
      prev_code   <= prev_code_next;
      fin         <= fin_next;
      if (cfg_valid && cfg_ready) min_code_size <= cfg_data;
      if (state == S_OUT) out_full <= 1'b1;
      else if (out_full && !out_stall) out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_reg    <= in_data.op;
      in_q_byte <= in_data.data_byte;
    end
    cur_code  <= cur_code_next;
    walk      <= walk_next;
    kwk       <= kwk_next;
    wn        <= wn_next;
    res       <= res_next;
    first_reg <= first_next;
  end

  `ASSERT_CLK(a_no_accept_busy, clk, rst, in_acc |-> state == S_IDLE, "accept while busy")
  `ASSERT_CLK(a_out_once, clk, rst, state == S_OUT |-> !out_full, "result overrun")
  `ASSERT_CLK(a_bits_bound, clk, rst, bit_count <= 5'd24, "bit count beyond buffer")
  `ASSERT_CLK(a_pix_ok, clk, rst, out_full && res.pixel_valid |-> res.status == ST_OK, "bad status")

endmodule
